// ===== design/ggc_pkg.sv =====
// Shared types and constants for the grid graph-cut edge weight block.
`default_nettype none

package ggc_pkg;

  // Width of each frame-size register.
  localparam int CFG_W = 11;

  // Frame size after reset.
  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd1024;

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 4;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
  } cfg_t;

endpackage : ggc_pkg

`default_nettype wire

// ===== design/ggc_front.sv =====
// Front part: position counters, term arithmetic, line buffer and stage register.
`default_nettype none

module ggc_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int ENERGY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ggc_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ENERGY_BITS-1:0] unary_background_i,
  input  logic signed [ENERGY_BITS-1:0] unary_foreground_i,
  input  logic signed [ENERGY_BITS-1:0] down_e00_i,
  input  logic signed [ENERGY_BITS-1:0] down_e10_i,
  input  logic signed [ENERGY_BITS-1:0] down_e01_i,
  input  logic signed [ENERGY_BITS-1:0] down_e11_i,
  input  logic signed [ENERGY_BITS-1:0] right_e00_i,
  input  logic signed [ENERGY_BITS-1:0] right_e10_i,
  input  logic signed [ENERGY_BITS-1:0] right_e01_i,
  input  logic signed [ENERGY_BITS-1:0] right_e11_i,
  output logic                          st_valid_o,
  input  logic                          st_ready_i,
  output logic signed [ENERGY_BITS+4:0] st_c_o,
  output logic signed [ENERGY_BITS+1:0] st_down_edge_o,
  output logic signed [ENERGY_BITS+1:0] st_right_edge_o
);

  localparam int TW   = ENERGY_BITS + 2;
  localparam int CW   = ENERGY_BITS + 5;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int XLW0 = $clog2(MAX_WIDTH + 1);
  localparam int YLW0 = $clog2(MAX_HEIGHT + 1);
  localparam int XLW  = (XLW0 > ggc_pkg::CFG_W) ? XLW0 : ggc_pkg::CFG_W;
  localparam int YLW  = (YLW0 > ggc_pkg::CFG_W) ? YLW0 : ggc_pkg::CFG_W;

  // effective frame size
  logic [XLW-1:0] w_reg, w_eff;
  logic [YLW-1:0] h_reg, h_eff;

  assign w_reg = XLW'(cfg_i.image_width);
  assign h_reg = YLW'(cfg_i.image_height);

  always_comb begin
    priority if (w_reg == '0)               w_eff = XLW'(1);
    else if (w_reg > XLW'(MAX_WIDTH))       w_eff = XLW'(MAX_WIDTH);
    else                                    w_eff = w_reg;
    priority if (h_reg == '0)               h_eff = YLW'(1);
    else if (h_reg > YLW'(MAX_HEIGHT))      h_eff = YLW'(MAX_HEIGHT);
    else                                    h_eff = h_reg;
  end

  // counters and left term
  logic [XW-1:0]        col_q, col_d;
  logic [YW-1:0]        row_q, row_d;
  logic signed [TW-1:0] left_q;
  logic                 st_vld_q, st_vld_d;
  logic                 acc, last_col, last_row;

  assign in_ready_o = !st_vld_q || st_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign last_col   = (XLW'(col_q) + XLW'(1)) >= w_eff;
  assign last_row   = (YLW'(row_q) + YLW'(1)) >= h_eff;

  // term arithmetic
  logic signed [TW-1:0] d00, d10, d01, d11, r00, r10, r01, r11;
  logic signed [TW-1:0] down_term, right_term, down_edge, right_edge;
  logic signed [TW-1:0] down_use, right_use, left_use;
  logic signed [CW-1:0] c1;

  assign d00 = TW'(down_e00_i);
  assign d10 = TW'(down_e10_i);
  assign d01 = TW'(down_e01_i);
  assign d11 = TW'(down_e11_i);
  assign r00 = TW'(right_e00_i);
  assign r10 = TW'(right_e10_i);
  assign r01 = TW'(right_e01_i);
  assign r11 = TW'(right_e11_i);

  assign down_term  = d10 + d11 - d01 - d00;
  assign right_term = r10 + r11 - r01 - r00;
  assign down_edge  = d10 + d01 - d11 - d00;
  assign right_edge = r10 + r01 - r11 - r00;

  assign down_use  = last_row ? '0 : down_term;
  assign right_use = last_col ? '0 : right_term;
  assign left_use  = (col_q != '0) ? left_q : '0;

  assign c1 = CW'(unary_foreground_i) - CW'(unary_background_i) + CW'(down_use)
            + CW'(left_use) + CW'(right_use);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    st_vld_d = st_vld_q;
    if (st_ready_i) begin
      st_vld_d = 1'b0;
    end
    if (acc) begin
      st_vld_d = 1'b1;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + YW'(1);
      end else begin
        col_d = col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      st_vld_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      st_vld_q <= st_vld_d;
      if (acc) begin
        left_q <= right_term;
      end
    end
  end

  // line buffer of down terms, one entry per column; read-before-write
  logic signed [TW-1:0] line_mem [MAX_WIDTH];
  logic signed [TW-1:0] upper_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_mem[col_q] <= down_term;
      upper_q         <= line_mem[col_q];
    end
  end

  // stage payload
  logic signed [CW-1:0] c1_q;
  logic                 use_upper_q;
  logic signed [TW-1:0] down_edge_q, right_edge_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      c1_q         <= c1;
      use_upper_q  <= (row_q != '0);
      down_edge_q  <= last_row ? '0 : down_edge;
      right_edge_q <= last_col ? '0 : right_edge;
    end
  end

  assign st_valid_o      = st_vld_q;
  assign st_c_o          = c1_q + (use_upper_q ? CW'(upper_q) : CW'(0));
  assign st_down_edge_o  = down_edge_q;
  assign st_right_edge_o = right_edge_q;

`ifndef NO_ASSERTIONS
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_col |=> col_q == '0)
    else $error("column counter did not wrap at last column");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !last_col |=> (col_q == $past(col_q) + XW'(1)) && (row_q == $past(row_q)))
    else $error("column counter did not step");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_vld_q && !st_ready_i |=> st_vld_q && $stable(c1_q))
    else $error("stage word lost while queue full");
`endif

endmodule : ggc_front

`default_nettype wire

// ===== design/ggc_fifo.sv =====
// Short queue between the front and back parts.
`default_nettype none

module ggc_fifo #(
  parameter int DATA_W = 57
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int DEPTH = ggc_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != NW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + NW'(1);
      2'b01:   cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == NW'(DEPTH)) |-> wr_q == rd_q)
    else $error("queue pointers disagree with count");
`endif

endmodule : ggc_fifo

`default_nettype wire

// ===== design/ggc_back.sv =====
// Back part: splits the pixel sum into source and terminal weights, output register.
`default_nettype none

module ggc_back #(
  parameter int ENERGY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  logic signed [ENERGY_BITS+4:0] q_c_i,
  input  logic signed [ENERGY_BITS+1:0] q_down_edge_i,
  input  logic signed [ENERGY_BITS+1:0] q_right_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ENERGY_BITS+3:0]        source_weight_o,
  output logic [ENERGY_BITS+3:0]        terminal_weight_o,
  output logic signed [ENERGY_BITS+1:0] down_edge_weight_o,
  output logic signed [ENERGY_BITS+1:0] right_edge_weight_o
);

  localparam int CW = ENERGY_BITS + 5;
  localparam int SW = ENERGY_BITS + 4;

  logic                 out_vld_q;
  logic                 take;
  logic signed [CW-1:0] neg_c;
  logic [SW-1:0]        src_d, term_d;

  assign q_ready_o = !out_vld_q || out_ready_i;
  assign take      = q_valid_i && q_ready_o;
  assign neg_c     = -q_c_i;
  assign src_d     = q_c_i[CW-1] ? '0 : q_c_i[SW-1:0];
  assign term_d    = q_c_i[CW-1] ? neg_c[SW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (q_ready_o) begin
      out_vld_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      source_weight_o     <= src_d;
      terminal_weight_o   <= term_d;
      down_edge_weight_o  <= q_down_edge_i;
      right_edge_weight_o <= q_right_edge_i;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule : ggc_back

`default_nettype wire

// ===== design/grid_graph_cut_edge_weights_top.sv =====
// Top level of the grid graph-cut edge weight block: config port and part wiring.
// The result word passes the stage register, the queue and the output register from input accept to the output.
// Throughput: one pixel word per cycle while neither side stalls; the line-buffer read for a column is issued
//   at accept and lands in the stage register alongside the partial sum.
// A 4-word queue sits between front and back so either side can stall alone.
// Reset (rst_ni, async low) clears counters, left term and all valid flags;
//   frame size returns to 1024 x 1024. The line buffer is not cleared.
`default_nettype none

module grid_graph_cut_edge_weights_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int ENERGY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ENERGY_BITS-1:0] unary_background_i,
  input  logic signed [ENERGY_BITS-1:0] unary_foreground_i,
  input  logic signed [ENERGY_BITS-1:0] down_e00_i,
  input  logic signed [ENERGY_BITS-1:0] down_e10_i,
  input  logic signed [ENERGY_BITS-1:0] down_e01_i,
  input  logic signed [ENERGY_BITS-1:0] down_e11_i,
  input  logic signed [ENERGY_BITS-1:0] right_e00_i,
  input  logic signed [ENERGY_BITS-1:0] right_e10_i,
  input  logic signed [ENERGY_BITS-1:0] right_e01_i,
  input  logic signed [ENERGY_BITS-1:0] right_e11_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ENERGY_BITS+3:0]        source_weight_o,
  output logic [ENERGY_BITS+3:0]        terminal_weight_o,
  output logic signed [ENERGY_BITS+1:0] down_edge_weight_o,
  output logic signed [ENERGY_BITS+1:0] right_edge_weight_o
);

  localparam int TW = ENERGY_BITS + 2;
  localparam int CW = ENERGY_BITS + 5;
  localparam int QW = CW + 2 * TW;

  // ---------------------------------------------------------------------------
  // Config registers. Word address selects by paddr[2]; low address bits ignored.
  // The user writes them only while the pipeline is idle (not enforced), so no shadowing is needed.
  // ---------------------------------------------------------------------------
  ggc_pkg::cfg_t      cfg_q;
  ggc_pkg::reg_idx_e  reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = ggc_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= ggc_pkg::WIDTH_RST;
      cfg_q.image_height <= ggc_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ggc_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[ggc_pkg::CFG_W-1:0];
        ggc_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[ggc_pkg::CFG_W-1:0];
        default:                   cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ggc_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_q.image_width);
      ggc_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.image_height);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front: counters, terms, line buffer, partial sum. Emits full sum c per word.
  // ---------------------------------------------------------------------------
  logic                 st_valid, st_ready;
  logic signed [CW-1:0] st_c;
  logic signed [TW-1:0] st_down_edge, st_right_edge;

  ggc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ENERGY_BITS(ENERGY_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .unary_background_i(unary_background_i),
    .unary_foreground_i(unary_foreground_i),
    .down_e00_i        (down_e00_i),
    .down_e10_i        (down_e10_i),
    .down_e01_i        (down_e01_i),
    .down_e11_i        (down_e11_i),
    .right_e00_i       (right_e00_i),
    .right_e10_i       (right_e10_i),
    .right_e01_i       (right_e01_i),
    .right_e11_i       (right_e11_i),
    .st_valid_o        (st_valid),
    .st_ready_i        (st_ready),
    .st_c_o            (st_c),
    .st_down_edge_o    (st_down_edge),
    .st_right_edge_o   (st_right_edge)
  );

  // ---------------------------------------------------------------------------
  // Queue: word = {c, down edge, right edge}
  // ---------------------------------------------------------------------------
  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  ggc_fifo #(
    .DATA_W(QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(st_valid),
    .push_ready_o(st_ready),
    .push_data_i ({st_c, st_down_edge, st_right_edge}),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  // ---------------------------------------------------------------------------
  // Back: sign split into source/terminal weight, registered output.
  // ---------------------------------------------------------------------------
  ggc_back #(
    .ENERGY_BITS(ENERGY_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_ready_o          (q_ready),
    .q_c_i              (q_data[QW-1 -: CW]),
    .q_down_edge_i      (q_data[2*TW-1 -: TW]),
    .q_right_edge_i     (q_data[TW-1:0]),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .source_weight_o    (source_weight_o),
    .terminal_weight_o  (terminal_weight_o),
    .down_edge_weight_o (down_edge_weight_o),
    .right_edge_weight_o(right_edge_weight_o)
  );

endmodule : grid_graph_cut_edge_weights_top

`default_nettype wire

// ===== dv/grid_graph_cut_edge_weights_top_tb.sv =====
// Self-checking testbench for the grid graph-cut edge weight block.
`timescale 1ns / 100ps

module grid_graph_cut_edge_weights_top_tb;

  localparam int EB            = 16;
  localparam int CW            = ggc_pkg::CFG_W;
  localparam int MAX_DIM       = 1024;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_MAX    = 10;
  localparam int RANDOM_PIXELS = 1000;
  // no idling on either side once this many random words are queued
  localparam int QUIET_AFTER   = 880;
  localparam int DRAIN_CYCLES  = 10;

  localparam logic signed [EB-1:0] E_MAX  = 16'sh7FFF;
  localparam logic signed [EB-1:0] E_MIN  = 16'sh8000;
  localparam logic signed [EB-1:0] E_ZERO = 16'sh0000;
  localparam logic signed [EB-1:0] E_NEG1 = 16'shFFFF;

  // how the energies of one pixel word are chosen
  typedef enum {
    FILL_RANDOM, FILL_EXTREME, FILL_SMALL, FILL_ZERO,
    FILL_MAX_C, FILL_MIN_C, FILL_EDGE_MAX, FILL_EDGE_MIN
  } fill_e;

  typedef struct packed {
    logic signed [EB-1:0] ub, uf, d00, d10, d01, d11, r00, r10, r01, r11;
  } pixel_t;

  typedef struct packed {
    logic        [EB+3:0] src_w;
    logic        [EB+3:0] term_w;
    logic signed [EB+1:0] down_w;
    logic signed [EB+1:0] right_w;
  } weights_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel, penable, pwrite, pready;
  logic [2:0]           paddr;
  logic [31:0]          pwdata, prdata;
  logic                 in_valid_i, in_ready_o;
  logic                 out_valid_o, out_ready_i;
  pixel_t               drv_pix;
  logic [EB+3:0]        source_weight_o, terminal_weight_o;
  logic signed [EB+1:0] down_edge_weight_o, right_edge_weight_o;

  // stimulus and expectations
  pixel_t   pixels_todo[$];
  weights_t weights_due[$];
  int       bad_words;
  int       cycle_cnt;
  bit       quiet_tail;

  // sender and receiver idling state
  int send_gap, send_calm;
  int recv_stall, recv_calm;

  // predictor copy of config and frame state
  logic [CW-1:0] width_reg, height_reg;
  int            col_cnt, row_cnt, left_term;
  int            line_term [MAX_DIM];
  bit            line_seen [MAX_DIM];

  grid_graph_cut_edge_weights_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .unary_background_i  (drv_pix.ub),
    .unary_foreground_i  (drv_pix.uf),
    .down_e00_i          (drv_pix.d00),
    .down_e10_i          (drv_pix.d10),
    .down_e01_i          (drv_pix.d01),
    .down_e11_i          (drv_pix.d11),
    .right_e00_i         (drv_pix.r00),
    .right_e10_i         (drv_pix.r10),
    .right_e01_i         (drv_pix.r01),
    .right_e11_i         (drv_pix.r11),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .source_weight_o     (source_weight_o),
    .terminal_weight_o   (terminal_weight_o),
    .down_edge_weight_o  (down_edge_weight_o),
    .right_edge_weight_o (right_edge_weight_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // register value -> frame dimension actually used (0 acts as 1, clamp at max)
  function automatic int frame_dim(logic [CW-1:0] r, int lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return int'(r);
  endfunction

  function automatic logic signed [EB-1:0] energy(fill_e f);
    logic [31:0] r;
    r = $urandom;
    case (f)
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return E_MAX;
          1: return E_MIN;
          2: return E_ZERO;
          3: return E_NEG1;
          default: return r[EB-1:0];
        endcase
      end
      FILL_SMALL: return EB'($signed($urandom_range(0, 511)) - 256);
      default: return r[EB-1:0];
    endcase
  endfunction

  function automatic pixel_t make_pixel(fill_e f);
    pixel_t p;
    case (f)
      FILL_ZERO: p = '0;
      // every t() at its top and U1 - U0 at its top: interior c hits the max
      FILL_MAX_C: begin
        p.ub  = E_MIN; p.uf  = E_MAX;
        p.d10 = E_MAX; p.d11 = E_MAX; p.d01 = E_MIN; p.d00 = E_MIN;
        p.r10 = E_MAX; p.r11 = E_MAX; p.r01 = E_MIN; p.r00 = E_MIN;
      end
      FILL_MIN_C: begin
        p.ub  = E_MAX; p.uf  = E_MIN;
        p.d10 = E_MIN; p.d11 = E_MIN; p.d01 = E_MAX; p.d00 = E_MAX;
        p.r10 = E_MIN; p.r11 = E_MIN; p.r01 = E_MAX; p.r00 = E_MAX;
      end
      FILL_EDGE_MAX: begin
        p.ub  = energy(FILL_RANDOM); p.uf = energy(FILL_RANDOM);
        p.d10 = E_MAX; p.d01 = E_MAX; p.d11 = E_MIN; p.d00 = E_MIN;
        p.r10 = E_MAX; p.r01 = E_MAX; p.r11 = E_MIN; p.r00 = E_MIN;
      end
      FILL_EDGE_MIN: begin
        p.ub  = energy(FILL_RANDOM); p.uf = energy(FILL_RANDOM);
        p.d10 = E_MIN; p.d01 = E_MIN; p.d11 = E_MAX; p.d00 = E_MAX;
        p.r10 = E_MIN; p.r01 = E_MIN; p.r11 = E_MAX; p.r00 = E_MAX;
      end
      default: begin
        p.ub  = energy(f); p.uf  = energy(f);
        p.d00 = energy(f); p.d10 = energy(f); p.d01 = energy(f); p.d11 = energy(f);
        p.r00 = energy(f); p.r10 = energy(f); p.r01 = energy(f); p.r11 = energy(f);
      end
    endcase
    return p;
  endfunction

  // Append one freshly made pixel word to the send queue.
  task automatic queue_pixel(fill_e f);
    pixels_todo = {pixels_todo, make_pixel(f)};
  endtask

  // Expected weights for one accepted pixel word; advances the frame state.
  task automatic cut_weights(pixel_t p);
    int       w, h, dterm, rterm, dedge, redge, c, mag;
    bit       lc, lr;
    weights_t e;
    w     = frame_dim(width_reg, MAX_DIM);
    h     = frame_dim(height_reg, MAX_DIM);
    dterm = p.d10 + p.d11 - p.d01 - p.d00;
    rterm = p.r10 + p.r11 - p.r01 - p.r00;
    dedge = p.d10 + p.d01 - p.d11 - p.d00;
    redge = p.r10 + p.r01 - p.r11 - p.r00;
    // a counter at or past the last column/row (after a shrink) counts as last
    lc    = (col_cnt + 1 >= w);
    lr    = (row_cnt + 1 >= h);
    c     = p.uf - p.ub;
    if (row_cnt > 0) c += line_term[col_cnt];
    if (!lr)         c += dterm;
    if (col_cnt > 0) c += left_term;
    if (!lc)         c += rterm;
    mag       = -c;
    e.src_w   = (c >= 0) ? c[EB+3:0] : '0;
    e.term_w  = (c < 0) ? mag[EB+3:0] : '0;
    e.down_w  = lr ? '0 : dedge[EB+1:0];
    e.right_w = lc ? '0 : redge[EB+1:0];
    weights_due = {weights_due, e};
    // terms are stored even on the last row/column
    line_term[col_cnt] = dterm;
    line_seen[col_cnt] = 1'b1;
    left_term          = rterm;
    if (lc) begin
      col_cnt = 0;
      row_cnt = lr ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endtask

  // Driver: presents pixel words, holds each until accepted, idles in bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) cut_weights(drv_pix);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pixels_todo.size() > 0) begin
          if (!quiet_tail && send_calm == 0 && $urandom_range(0, 5) == 0) begin
            // this cycle idles too and counts as part of the idle burst
            send_gap   = $urandom_range(1, 19) - 1;
            in_valid_i <= 1'b0;
          end else begin
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 9) == 0) send_calm = $urandom_range(10, 60);
            drv_pix    <= pixels_todo.pop_front();
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expectation,
  // and stalls the output in bursts.
  always @(posedge clk_i) begin
    weights_t got, exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{source_weight_o, terminal_weight_o, down_edge_weight_o,
                right_edge_weight_o};
        if (weights_due.size() == 0) begin
          bad_words++;
          if (bad_words <= REPORT_MAX)
            $display("%0t: result word with nothing expected: src=%0d term=%0d down=%0d right=%0d",
                     $realtime, got.src_w, got.term_w, got.down_w, got.right_w);
        end else begin
          exp_w = weights_due.pop_front();
          if (got !== exp_w) begin
            bad_words++;
            if (bad_words <= REPORT_MAX)
              $display("%0t: mismatch exp src=%0d term=%0d down=%0d right=%0d, got src=%0d term=%0d down=%0d right=%0d",
                       $realtime, exp_w.src_w, exp_w.term_w, exp_w.down_w, exp_w.right_w,
                       got.src_w, got.term_w, got.down_w, got.right_w);
          end
        end
      end
      if (recv_stall > 0) recv_stall--;
      else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 9) == 0)
        recv_stall = $urandom_range(1, 19);
      else if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(10, 80);
      out_ready_i <= (recv_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("grid_graph_cut_edge_weights_top_tb NOT OK");
      $finish;
    end
  end

  // Block until no word is pending, in flight or owed.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixels_todo.size() != 0 || in_valid_i || weights_due.size() != 0);
  endtask

  // APB write then read-back of one frame-size register; ends on a falling edge.
  task automatic apb_access(ggc_pkg::reg_idx_e idx, logic [CW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register takes the value at this edge
    if (idx == ggc_pkg::REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[CW-1:0] !== val) begin
      bad_words++;
      if (bad_words <= REPORT_MAX)
        $display("%0t: read-back of register %s: exp %0d got %0d",
                 $realtime, idx.name(), val, prdata[CW-1:0]);
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Frame-size change once idle. A widening in the middle of a row past the
  // first is only allowed if every column the row will still read holds a
  // stored down term; otherwise the old width is written again.
  task automatic reconfigure(logic [CW-1:0] w, logic [CW-1:0] h,
                             bit set_w, bit set_h);
    bit ok;
    wait_drained();
    if (set_w) begin
      ok = 1'b1;
      if (row_cnt > 0)
        for (int i = col_cnt; i < frame_dim(w, MAX_DIM); i++)
          if (!line_seen[i]) ok = 1'b0;
      apb_access(ggc_pkg::REG_IMAGE_WIDTH, ok ? w : width_reg);
    end
    if (set_h) apb_access(ggc_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // Mostly small frames, now and then zero, full size or past the max.
  function automatic logic [CW-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CW'($urandom_range(1, 6));
    if (r < 75) return CW'($urandom_range(7, 40));
    if (r < 80) return '0;
    if (r < 84) return CW'(MAX_DIM);
    if (r < 87) return CW'($urandom_range(MAX_DIM + 1, 2046));
    if (r < 90) return '1;
    return CW'($urandom_range(41, MAX_DIM - 1));
  endfunction

  initial begin
    int    sent, n, r;
    fill_e fill;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    drv_pix     = '0;
    bad_words   = 0;
    cycle_cnt   = 0;
    quiet_tail  = 1'b0;
    send_gap    = 0;
    send_calm   = 0;
    recv_stall  = 0;
    recv_calm   = 0;
    width_reg   = ggc_pkg::WIDTH_RST;
    height_reg  = ggc_pkg::HEIGHT_RST;
    col_cnt     = 0;
    row_cnt     = 0;
    left_term   = 0;
    foreach (line_term[i]) begin
      line_term[i] = 0;
      line_seen[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset frame size; edge weights at both extremes
    queue_pixel(FILL_ZERO);
    queue_pixel(FILL_EDGE_MAX);
    queue_pixel(FILL_EDGE_MIN);
    queue_pixel(FILL_EXTREME);
    queue_pixel(FILL_RANDOM);
    // zero size acts as 1x1, written mid-row: next word is last and wraps
    reconfigure('0, '0, 1'b1, 1'b1);
    repeat (2) queue_pixel(FILL_EXTREME);
    // 3x3 frames: center pixel reaches the largest and smallest c
    reconfigure(CW'(3), CW'(3), 1'b1, 1'b1);
    repeat (9) queue_pixel(FILL_MAX_C);
    repeat (9) queue_pixel(FILL_MIN_C);

    // random phases; each size change waits for all results first
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      r = $urandom_range(0, 2);
      reconfigure(pick_dim(), pick_dim(), r != 2, r != 1);
      r    = $urandom_range(0, 9);
      fill = (r < 6) ? FILL_RANDOM : (r < 8) ? FILL_EXTREME : FILL_SMALL;
      n    = $urandom_range(4, 60);
      if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
      repeat (n) begin
        if (sent >= QUIET_AFTER) quiet_tail = 1'b1;
        queue_pixel(fill);
        sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_words == 0) begin
      $display("grid_graph_cut_edge_weights_top_tb OK");
    end else begin
      $display("grid_graph_cut_edge_weights_top_tb NOT OK");
    end
    $finish;
  end

endmodule
